[sv/hst_pkg.sv]
`timescale 1ns / 1ps

package hst_pkg;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BAD  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic [15:0] INST_RESET = 16'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] object_id;
    logic [31:0] handle_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [31:0] object_out;
  } out_word_t;

  typedef struct packed {
    logic        used;
    logic [31:0] object;
  } slot_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK
  } state_t;

endpackage

[sv/hst_ram.sv]
`timescale 1ns / 1ps

module hst_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/handle_slot_table.sv]
// results: append or full add and bad-index requests give their result in the cycle after start;
// remove and lookup check the slot in S_CHECK before the result is registered; an add that reuses a freed
// slot steps S_SCAN through the entries from slot 0 up to the lowest free slot below the high-water mark.
// no new request is taken while busy; busy drops as the result is strobed; the search reads one entry a cycle
// reset (rst_n low, synchronous) clears the mark, the free count and sets the counter to one;
// the slot memory is not cleared. results are strobed for one cycle and cannot be stalled.
`timescale 1ns / 1ps

module handle_slot_table
  import hst_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = $bits(slot_entry_t);

  // sequencer and bookkeeping
  state_t          state_r, state_nxt;
  in_word_t        req_r, req_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]   hw_r, hw_nxt;       // high-water mark, slots ever appended
  logic [CW-1:0]   free_r, free_nxt;   // freed slots below the mark
  logic [15:0]     inst_r, inst_nxt;   // instance counter
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_word_r, out_word_nxt;

  // slot memory port signals
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  slot_entry_t     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;
  slot_entry_t     rd_ent;

  logic [15:0]     idx;
  logic            idx_ok;
  logic            full;
  logic            accept;

  hst_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent = slot_entry_t'(ram_rdata);

  // 1-based slot index from the handle; the instance bits are not checked
  assign idx    = in_word.handle_in[15:0];
  assign idx_ok = (idx != 16'd0) && (idx <= 16'(hw_r));
  assign full   = (hw_r == CW'(SLOTS));
  assign accept = start && (state_r == S_IDLE);

  // read port: slot named by the handle, start of the search, or the next entry to look at
  always_comb begin
    case (state_r)
      S_IDLE: begin
        if (in_word.req_type == REQ_ADD) begin
          ram_raddr = '0;
        end else begin
          ram_raddr = AW'(idx - 16'd1);
        end
      end
      S_SCAN:  ram_raddr = ptr_r + AW'(1);
      default: ram_raddr = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      free_r      <= '0;
      inst_r      <= INST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      free_r      <= free_nxt;
      inst_r      <= inst_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    ptr_r      <= ptr_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    ptr_nxt       = ptr_r;
    hw_nxt        = hw_r;
    free_nxt      = free_r;
    inst_nxt      = inst_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt      = in_word;
          out_word_nxt = '0;
          case (in_word.req_type)
            REQ_ADD: begin
              if (free_r != '0) begin
                // a freed slot exists below the mark: search from slot 0
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end else if (full) begin
                out_word_nxt.status = STAT_FULL;
                out_valid_nxt       = 1'b1;
              end else begin
                // append at the mark: use the counter, then bump it
                ram_we                  = 1'b1;
                ram_waddr               = AW'(hw_r);
                ram_wdata.used          = 1'b1;
                ram_wdata.object        = in_word.object_id;
                hw_nxt                  = hw_r + CW'(1);
                inst_nxt                = inst_r + 16'd1;
                out_word_nxt.status     = STAT_OK;
                out_word_nxt.handle_out = {inst_r, 16'(hw_r) + 16'd1};
                out_valid_nxt           = 1'b1;
              end
            end
            REQ_REMOVE, REQ_LOOKUP: begin
              if (idx_ok) begin
                ptr_nxt   = AW'(idx - 16'd1);
                state_nxt = S_CHECK;
              end else begin
                out_word_nxt.status = STAT_BAD;
                out_valid_nxt       = 1'b1;
              end
            end
            default: begin
              out_word_nxt.status = STAT_BAD;
              out_valid_nxt       = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read data belongs to ptr_r; the next entry is already being read
        if (!rd_ent.used) begin
          // reuse: bump the counter first, then use it
          ram_we                  = 1'b1;
          ram_waddr               = ptr_r;
          ram_wdata.used          = 1'b1;
          ram_wdata.object        = req_r.object_id;
          inst_nxt                = inst_r + 16'd1;
          free_nxt                = free_r - CW'(1);
          out_word_nxt.status     = STAT_OK;
          out_word_nxt.handle_out = {inst_r + 16'd1, 16'(ptr_r) + 16'd1};
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      S_CHECK: begin
        if (rd_ent.used) begin
          out_word_nxt.status = STAT_OK;
          if (req_r.req_type == REQ_LOOKUP) begin
            out_word_nxt.object_out = rd_ent.object;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ptr_r;
            ram_wdata = '0;
            free_nxt  = free_r + CW'(1);
          end
        end else begin
          out_word_nxt.status = STAT_BAD;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  // freed slots all lie below the mark
  a_free_le_mark: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= hw_r)
    else $error("free count above high-water mark");

  // the mark never shrinks
  a_mark_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hw_r >= $past(hw_r))
    else $error("high-water mark went down");

  // full is only reported once every slot has been appended
  a_full_only_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status == STAT_FULL) |-> $past(hw_r) == CW'(SLOTS))
    else $error("full status with room left");

  // the reuse search stays below the mark and only runs with a free slot present
  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (free_r != '0) && (CW'(ptr_r) < hw_r))
    else $error("slot search ran past the mark");
`endif

endmodule
